// ===== src/frs_pkg.sv =====
// ----------------------------------------------------------------------------
// frs_pkg
// Shared widths and codes of the full-text rank score block.
// ----------------------------------------------------------------------------
package frs_pkg;

  localparam int WORD_W    = 32;
  localparam int SCORE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int WEIGHT_W  = 48;
  localparam int FRAC_W    = 16;
  localparam int F_W       = 19;

  localparam int DIV_N_W   = 64;
  localparam int DIV_D_W   = 50;
  localparam int DIV_Q_W   = 34;
  localparam int DIV_C_W   = 6;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_HITS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LOG_ARG = 2'd3;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};
  localparam logic [31:0]         ONE_Q16    = 32'd65536;

  typedef logic [WORD_W-1:0] word_t;

endpackage

// ===== src/frs_in_if.sv =====
// ----------------------------------------------------------------------------
// frs_in_if
// Request channel carrying one match-info word per request.
// ----------------------------------------------------------------------------
interface frs_in_if;
  import frs_pkg::*;
  logic  valid;
  logic  ready;
  word_t word;
  logic  last;
  modport source(output valid, output word, output last, input ready);
  modport sink(input valid, input word, input last, output ready);
endinterface

// ===== src/frs_out_if.sv =====
// ----------------------------------------------------------------------------
// frs_out_if
// Result channel carrying the rank score and status.
// ----------------------------------------------------------------------------
interface frs_out_if;
  import frs_pkg::*;
  logic                valid;
  logic                ready;
  logic [SCORE_W-1:0]  score;
  logic [STATUS_W-1:0] status;
  modport source(output valid, output score, output status, input ready);
  modport sink(input valid, input score, input status, output ready);
endinterface

// ===== src/frs_div.sv =====
// ----------------------------------------------------------------------------
// frs_div
// Restoring divider, one quotient bit per cycle. The numerator bits above
// the quotient width must form a value below the divisor.
// ----------------------------------------------------------------------------
module frs_div import frs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] num,
  input  logic [DIV_D_W-1:0] den,
  output logic               done,
  output logic [DIV_Q_W-1:0] quo
);

  logic               busy;
  logic [DIV_C_W-1:0] cnt;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W-1:0] dreg;
  logic [DIV_Q_W-1:0] nsh;
  logic [DIV_D_W:0]   trial;
  logic [DIV_D_W:0]   diff;
  logic               ge;

  assign trial = {rem, nsh[DIV_Q_W-1]};
  assign ge    = trial >= {1'b0, dreg};
  assign diff  = trial - {1'b0, dreg};
  assign quo   = nsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= {{(DIV_D_W-(DIV_N_W-DIV_Q_W)){1'b0}}, num[DIV_N_W-1:DIV_Q_W]};
        nsh  <= num[DIV_Q_W-1:0];
        dreg <= den;
      end else if (busy) begin
        rem <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
        nsh <= {nsh[DIV_Q_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_C_W'(DIV_Q_W-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/frs_log2.sv =====
// ----------------------------------------------------------------------------
// frs_log2
// Base-2 logarithm in Q16: binary-search normalize, then sixteen
// squaring steps for the fraction.
// ----------------------------------------------------------------------------
module frs_log2 import frs_pkg::*; #(
  parameter int U_W = 40
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [U_W-1:0]          u,
  output logic                    done,
  output logic [$clog2(U_W)+FRAC_W-1:0] res
);

  localparam int E_W = $clog2(U_W);
  localparam int K_W = $clog2(E_W);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_NORM = 2'd1;
  localparam logic [1:0] PH_SQ   = 2'd2;

  logic [1:0]        ph;
  logic [U_W-1:0]    x;
  logic [E_W-1:0]    sh;
  logic [E_W-1:0]    expo;
  logic [K_W-1:0]    k;
  logic [30:0]       m;
  logic [FRAC_W-1:0] frac;
  logic [3:0]        it;
  logic [E_W:0]      amt;
  logic [E_W:0]      rsh;
  logic              top_zero;
  logic [61:0]       sq;
  logic [31:0]       t;

  assign amt      = (E_W+1)'(1) << k;
  assign rsh      = (E_W+1)'(U_W) - amt;
  assign top_zero = (x >> rsh) == '0;
  assign sq       = 62'(m) * 62'(m);
  assign t        = sq[61:30];
  assign res      = {expo, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= PH_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (ph)
        PH_IDLE: begin
          if (start) begin
            x  <= u;
            sh <= '0;
            k  <= K_W'(E_W-1);
            ph <= PH_NORM;
          end
        end
        PH_NORM: begin
          if (top_zero) begin
            x  <= x << amt;
            sh <= sh + amt[E_W-1:0];
          end
          if (k == '0) begin
            ph <= PH_SQ;
          end else begin
            k <= k - 1'b1;
          end
        end
        PH_SQ: begin
          if (it == 4'd15) begin
            ph   <= PH_IDLE;
            done <= 1'b1;
          end
        end
        default: ph <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ph == PH_NORM && k == '0) begin
      m    <= top_zero ? x[U_W-2 -: 31] : x[U_W-1 -: 31];
      expo <= E_W'(U_W-1) - (top_zero ? sh + amt[E_W-1:0] : sh);
      frac <= '0;
      it   <= '0;
    end else if (ph == PH_SQ) begin
      frac <= {frac[FRAC_W-2:0], t[31]};
      m    <= t[31] ? t[31:1] : t[30:0];
      it   <= it + 1'b1;
    end
  end

endmodule

// ===== src/fulltext_rank_score.sv =====
// ----------------------------------------------------------------------------
// fulltext_rank_score
// BM25-style rank score over one match-info blob taken one word per request.
// Header, hit, row and average words are taken directly (hit words of later
// phrases add a read-modify-write of the hit sum); a length word of column 1
// and up with a nonzero average waits on the 34-step divider; the last word
// runs three logarithms and two divisions. One word is in work at a time.
// Reset is synchronous; the column memories are not cleared, the first
// phrase of each blob overwrites the hit sums.
// ----------------------------------------------------------------------------
module fulltext_rank_score import frs_pkg::*; #(
  parameter int MAX_COLS    = 64,
  parameter int MAX_PHRASES = 64
) (
  input  logic      clk,
  input  logic      rst,
  frs_in_if.sink    blob,
  frs_out_if.source rank
);

  localparam int TOT_MAX = 3 + 3*MAX_PHRASES*MAX_COLS + 3*MAX_COLS;
  localparam int POS_W   = $clog2(TOT_MAX+1);
  localparam int P_W     = $clog2(MAX_PHRASES+1);
  localparam int C_W     = $clog2(MAX_COLS+1);
  localparam int A_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int S_W     = WORD_W + $clog2(MAX_PHRASES+1);
  localparam int H_W     = WORD_W + $clog2(MAX_PHRASES*MAX_COLS+1);
  localparam int PN_W    = P_W + WORD_W;
  localparam int X_W     = (H_W > PN_W) ? H_W : PN_W;
  localparam int U_W     = PN_W + 1;
  localparam int L_W     = $clog2(U_W) + FRAC_W;
  localparam int T_W     = S_W + F_W;
  localparam int AC_W    = WORD_W + C_W;
  localparam int AD_W    = WORD_W + 2 + C_W;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_HITRD  = 5'd1;
  localparam logic [4:0] S_LENRD  = 5'd2;
  localparam logic [4:0] S_LENDIV = 5'd3;
  localparam logic [4:0] S_LENADD = 5'd4;
  localparam logic [4:0] S_PN     = 5'd5;
  localparam logic [4:0] S_CHK    = 5'd6;
  localparam logic [4:0] S_LOGA   = 5'd7;
  localparam logic [4:0] S_LOGB   = 5'd8;
  localparam logic [4:0] S_LOGC   = 5'd9;
  localparam logic [4:0] S_DEN    = 5'd10;
  localparam logic [4:0] S_MAG    = 5'd11;
  localparam logic [4:0] S_REC    = 5'd12;
  localparam logic [4:0] S_Q1     = 5'd13;
  localparam logic [4:0] S_Q2     = 5'd14;
  localparam logic [4:0] S_EMIT   = 5'd15;

  logic [4:0]          state;
  logic [POS_W-1:0]    pos;
  logic [P_W-1:0]      p_cnt;
  logic [C_W-1:0]      c_cnt;
  logic [H_W-1:0]      h_tot;
  logic [WORD_W-1:0]   rows;
  logic [WEIGHT_W-1:0] weight;
  logic                err;
  logic [1:0]          hit_rem;
  logic [C_W-1:0]      hit_col;
  logic                hit_first;
  word_t               w_reg;
  logic [C_W-1:0]      j_reg;
  logic [PN_W-1:0]     pn;
  logic [L_W-1:0]      la;
  logic [L_W-1:0]      lb;
  logic signed [L_W:0] num;
  logic signed [L_W:0] den;
  logic [DIV_Q_W-1:0]  mag;
  logic [29:0]         r;
  logic [59:0]         plo;
  logic [33:0]         phi;
  logic [T_W-1:0]      term;
  logic                out_valid;
  logic [SCORE_W-1:0]  out_score;
  logic [STATUS_W-1:0] out_status;
  logic [SCORE_W-1:0]  res_score;
  logic [STATUS_W-1:0] res_status;

  logic [S_W-1:0]      hit_mem [MAX_COLS];
  logic [WORD_W-1:0]   avg_mem [MAX_COLS];
  logic [S_W-1:0]      hit_rd;
  logic [WORD_W-1:0]   avg_rd;
  logic                hit_we;
  logic                hit_re;
  logic [A_W-1:0]      hit_addr;
  logic [S_W-1:0]      hit_wdata;
  logic                avg_we;
  logic                avg_re;
  logic [A_W-1:0]      avg_waddr;
  logic [A_W-1:0]      avg_raddr;

  logic [POS_W-1:0]    pc;
  logic [POS_W-1:0]    hit_end;
  logic [POS_W-1:0]    avg_end;
  logic [POS_W-1:0]    len_end;
  logic [POS_W-1:0]    total;
  logic [POS_W-1:0]    len_j;
  logic [POS_W-1:0]    avg_j;
  logic                acc;
  logic                take;
  logic                in_hit;
  logic                in_rows;
  logic                in_avg;
  logic                in_len;
  logic                in_over;
  logic                len_use;

  logic                div_start;
  logic [DIV_N_W-1:0]  div_num;
  logic [DIV_D_W-1:0]  div_den;
  logic                div_done;
  logic [DIV_Q_W-1:0]  div_quo;
  logic                log_start;
  logic [U_W-1:0]      log_u;
  logic                log_done;
  logic [L_W-1:0]      log_res;

  logic [AC_W-1:0]     f_num;
  logic [WORD_W+1:0]   f_sum;
  logic [AD_W-1:0]     f_den;
  logic [T_W:0]        wsum;
  logic [X_W-1:0]      pn_x;
  logic [X_W-1:0]      h_x;
  logic [L_W:0]        num_abs;
  logic [WEIGHT_W:0]   rec_d;
  logic [34:0]         q;
  logic                num_neg;

  assign acc        = blob.valid && blob.ready;
  assign blob.ready = state == S_IDLE;
  assign take       = acc && !blob.last && !err;

  assign pc      = POS_W'(p_cnt) * POS_W'(c_cnt);
  assign hit_end = POS_W'(2) + POS_W'(3) * pc;
  assign avg_end = hit_end + POS_W'(1) + POS_W'(c_cnt);
  assign len_end = avg_end + POS_W'(c_cnt);
  assign total   = len_end + POS_W'(c_cnt);
  assign len_j   = pos - avg_end;
  assign avg_j   = pos - hit_end - POS_W'(1);

  assign in_hit  = pos >= POS_W'(2) && pos < hit_end;
  assign in_rows = pos >= POS_W'(2) && pos == hit_end;
  assign in_avg  = pos > hit_end && pos < avg_end;
  assign in_len  = pos >= avg_end && pos < len_end;
  assign in_over = pos >= POS_W'(2) && pos >= total;
  assign len_use = in_len && len_j != '0;

  // column memories
  always_comb begin
    hit_we    = 1'b0;
    hit_re    = 1'b0;
    hit_addr  = A_W'(hit_col);
    hit_wdata = S_W'(blob.word);
    if (state == S_HITRD) begin
      hit_we    = 1'b1;
      hit_addr  = A_W'(j_reg);
      hit_wdata = hit_rd + S_W'(w_reg);
    end else if (take && in_hit && hit_rem == 2'd0) begin
      hit_we = hit_first;
      hit_re = !hit_first;
    end else if (take && len_use) begin
      hit_re   = 1'b1;
      hit_addr = A_W'(len_j);
    end
  end

  assign avg_we    = take && in_avg;
  assign avg_waddr = A_W'(avg_j);
  assign avg_re    = take && len_use;
  assign avg_raddr = A_W'(len_j);

  always_ff @(posedge clk) begin
    if (hit_we) begin
      hit_mem[hit_addr] <= hit_wdata;
    end
    if (hit_re) begin
      hit_rd <= hit_mem[hit_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (avg_we) begin
      avg_mem[avg_waddr] <= blob.word;
    end
    if (avg_re) begin
      avg_rd <= avg_mem[avg_raddr];
    end
  end

  // shared arithmetic units
  assign f_num   = AC_W'(avg_rd) * AC_W'(c_cnt - j_reg);
  assign f_sum   = (WORD_W+2)'(avg_rd) + (WORD_W+2)'({w_reg, 1'b0}) + (WORD_W+2)'(w_reg);
  assign f_den   = AD_W'(c_cnt) * AD_W'(f_sum);
  assign num_abs = num[L_W] ? (L_W+1)'(-num) : (L_W+1)'(num);
  assign rec_d   = (WEIGHT_W+1)'(weight) + (WEIGHT_W+1)'(2*ONE_Q16);

  always_comb begin
    div_start = 1'b0;
    div_num   = DIV_N_W'({f_num, 18'd0});
    div_den   = DIV_D_W'(f_den);
    if (state == S_LENRD) begin
      div_start = avg_rd != '0;
    end else if (state == S_DEN) begin
      div_start = den > 0;
      div_num   = DIV_N_W'({num_abs, 30'd0});
      div_den   = DIV_D_W'(den[L_W-1:0]);
    end else if (state == S_MAG) begin
      div_start = div_done;
      div_num   = DIV_N_W'(rec_d) + (DIV_N_W'(1) << 47) - DIV_N_W'(1);
      div_den   = DIV_D_W'(rec_d);
    end
  end

  assign pn_x = X_W'(pn);
  assign h_x  = X_W'(h_tot);

  always_comb begin
    log_start = 1'b0;
    log_u     = {(U_W-1)'(pn_x - h_x), 1'b0} | U_W'(1);
    if (state == S_CHK) begin
      log_start = h_x != '0 && pn_x >= h_x;
    end else if (state == S_LOGA) begin
      log_start = log_done;
      log_u     = {(U_W-1)'(h_tot), 1'b0};
    end else if (state == S_LOGB) begin
      log_start = log_done;
      log_u     = {pn, 1'b1};
    end
  end

  frs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  frs_log2 #(.U_W(U_W)) u_log (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .u     (log_u),
    .done  (log_done),
    .res   (log_res)
  );

  assign wsum    = (T_W+1)'(weight) + (T_W+1)'(term);
  assign q       = 35'(phi) + 35'(plo[59:30]);
  assign num_neg = num[L_W];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      p_cnt     <= '0;
      c_cnt     <= '0;
      h_tot     <= '0;
      rows      <= '0;
      weight    <= '0;
      err       <= 1'b0;
      hit_rem   <= '0;
      hit_col   <= '0;
      hit_first <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state == S_EMIT) || (out_valid && !rank.ready);
      unique case (state)
        S_IDLE: begin
          if (acc && blob.last) begin
            if (!err && pos >= POS_W'(2) && pos == total - POS_W'(1)) begin
              state <= S_PN;
            end else begin
              res_status <= ST_BAD;
              res_score  <= '0;
              state      <= S_EMIT;
            end
          end else if (acc) begin
            w_reg <= blob.word;
            if (pos != '1) begin
              pos <= pos + 1'b1;
            end
            if (!err) begin
              if (pos == '0) begin
                if (blob.word > WORD_W'(MAX_PHRASES)) err <= 1'b1;
                else p_cnt <= P_W'(blob.word);
              end else if (pos == POS_W'(1)) begin
                if (blob.word > WORD_W'(MAX_COLS)) err <= 1'b1;
                else c_cnt <= C_W'(blob.word);
              end else if (in_hit) begin
                j_reg <= hit_col;
                if (hit_rem == 2'd0 && !hit_first) begin
                  state <= S_HITRD;
                end
                if (hit_rem == 2'd2 && hit_col != '0) begin
                  h_tot <= h_tot + H_W'(blob.word);
                end
                if (hit_rem == 2'd2) begin
                  hit_rem <= '0;
                  if (hit_col == c_cnt - 1'b1) begin
                    hit_col   <= '0;
                    hit_first <= 1'b0;
                  end else begin
                    hit_col <= hit_col + 1'b1;
                  end
                end else begin
                  hit_rem <= hit_rem + 1'b1;
                end
              end else if (in_rows) begin
                rows <= blob.word;
              end else if (in_len) begin
                j_reg <= C_W'(len_j);
                if (len_use) begin
                  state <= S_LENRD;
                end
              end else if (in_over) begin
                err <= 1'b1;
              end
            end
          end
        end
        S_HITRD: state <= S_IDLE;
        S_LENRD: state <= (avg_rd != '0) ? S_LENDIV : S_IDLE;
        S_LENDIV: begin
          if (div_done) begin
            term  <= T_W'(hit_rd) * T_W'(div_quo[F_W-1:0]);
            state <= S_LENADD;
          end
        end
        S_LENADD: begin
          weight <= (wsum[T_W:WEIGHT_W] != '0) ? WEIGHT_MAX : wsum[WEIGHT_W-1:0];
          state  <= S_IDLE;
        end
        S_PN: begin
          pn    <= PN_W'(p_cnt) * PN_W'(rows);
          state <= S_CHK;
        end
        S_CHK: begin
          res_score <= '0;
          if (h_x == '0) begin
            res_status <= ST_NO_HITS;
            state      <= S_EMIT;
          end else if (pn_x < h_x) begin
            res_status <= ST_LOG_ARG;
            state      <= S_EMIT;
          end else begin
            state <= S_LOGA;
          end
        end
        S_LOGA: begin
          if (log_done) begin
            la    <= log_res;
            state <= S_LOGB;
          end
        end
        S_LOGB: begin
          if (log_done) begin
            lb    <= log_res;
            state <= S_LOGC;
          end
        end
        S_LOGC: begin
          if (log_done) begin
            num   <= $signed({1'b0, la}) - $signed({1'b0, lb});
            den   <= $signed({1'b0, log_res}) - $signed((L_W+1)'(ONE_Q16));
            state <= S_DEN;
          end
        end
        S_DEN: begin
          if (den > 0) begin
            state <= S_MAG;
          end else begin
            res_status <= ST_LOG_ARG;
            state      <= S_EMIT;
          end
        end
        S_MAG: begin
          if (div_done) begin
            mag   <= div_quo;
            state <= S_REC;
          end
        end
        S_REC: begin
          if (div_done) begin
            r     <= 30'(31'h4000_0000 - div_quo[30:0]);
            state <= S_Q1;
          end
        end
        S_Q1: begin
          plo   <= 60'(r) * 60'(mag[29:0]);
          phi   <= 34'(r) * 34'(mag[33:30]);
          state <= S_Q2;
        end
        S_Q2: begin
          res_status <= ST_OK;
          if (!num_neg) begin
            res_score <= (q > 35'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
          end else begin
            res_score <= (q >= 35'h0_8000_0000) ? 32'h8000_0000 : 32'(-q[31:0]);
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || rank.ready) begin
            out_score  <= res_score;
            out_status <= res_status;
            pos        <= '0;
            p_cnt      <= '0;
            c_cnt      <= '0;
            h_tot      <= '0;
            rows       <= '0;
            weight     <= '0;
            err        <= 1'b0;
            hit_rem    <= '0;
            hit_col    <= '0;
            hit_first  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rank.valid  = out_valid;
  assign rank.score  = out_score;
  assign rank.status = out_status;

endmodule

// ===== bench/tb_fulltext_rank_score.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fulltext_rank_score
// Self-checking bench for the rank score block. Match-info blobs (whole,
// truncated, overlong, oversize header) are streamed one word per request.
// Each closing word is scored by an in-bench copy of the fixed-point BM25
// math, and the score and status that come back are compared with it.
// Both sides idle and stall at random, then run at full rate at the end.
// ----------------------------------------------------------------------------
module tb_fulltext_rank_score;
  import frs_pkg::*;

  localparam int NCOLS      = 64;
  localparam int NPHRASES   = 64;
  localparam int WDOG_LIMIT = 2000;

  typedef enum {VAL_MIXED, VAL_MAX, VAL_ZERO_AVG, VAL_NO_ROWS} val_style_e;

  typedef struct packed {
    logic [SCORE_W-1:0]  score;
    logic [STATUS_W-1:0] status;
  } rank_t;

  logic clk;
  logic rst;
  frs_in_if  blob_if();
  frs_out_if rank_if();

  fulltext_rank_score dut (
    .clk  (clk),
    .rst  (rst),
    .blob (blob_if),
    .rank (rank_if)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // predictor state
  int unsigned     pos_q;
  int unsigned     phrases_q;
  int unsigned     cols_q;
  longint unsigned hit_sum_q [NCOLS];
  longint unsigned avg_q [NCOLS];
  longint unsigned docs_q;
  longint unsigned rows_q;
  longint unsigned weight_q;
  logic [1:0]      err_q;

  rank_t   score_fifo[$];
  word_t   blob_q[$];
  bit      steady;
  int      stall_left;
  int      words_sent;
  int      blobs_sent;
  int      scores_seen;
  int      mismatches;
  int      status_hist[4];
  int      idle_cycles;

  function automatic void clear_predictor();
    pos_q = 0; phrases_q = 0; cols_q = 0;
    foreach (hit_sum_q[i]) begin
      hit_sum_q[i] = 0;
      avg_q[i] = 0;
    end
    docs_q = 0; rows_q = 0; weight_q = 0; err_q = ST_OK;
  endfunction

  function automatic void add_word(word_t w);
    blob_q.insert(blob_q.size(), w);
  endfunction

  function automatic longint log2_q16(longint unsigned u);
    int e;
    longint unsigned t, m, frac;
    e = 0; t = u; frac = 0;
    while (t > 1) begin
      t >>= 1;
      e++;
    end
    m = (e <= 30) ? (u << (30 - e)) : (u >> (e - 30));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= (64'd1 << 31)) begin
        frac |= 1;
        m >>= 1;
      end
    end
    return longint'(e) * 65536 + longint'(frac);
  endfunction

  function automatic void weigh_length(int unsigned j, longint unsigned len);
    longint unsigned avg, numr, denr, f, term;
    if (j == 0 || j >= cols_q || j >= NCOLS) return;
    avg = avg_q[j];
    if (avg == 0) return;
    numr = 4 * avg * longint'(cols_q - j) * ONE_Q16;
    denr = longint'(cols_q) * (avg + 3 * len);
    f = numr / denr;
    term = hit_sum_q[j] * f;
    if (term > longint'(WEIGHT_MAX) - weight_q) weight_q = WEIGHT_MAX;
    else weight_q += term;
  endfunction

  function automatic void absorb_word(word_t w);
    longint unsigned p, hit_end, avg_end, len_end, total, k;
    int unsigned j;
    p = pos_q;
    if (p == 0) begin
      if (w > NPHRASES) err_q = ST_BAD; else phrases_q = w;
      return;
    end
    if (p == 1) begin
      if (w > NCOLS) err_q = ST_BAD; else cols_q = w;
      return;
    end
    hit_end = 2 + 3 * longint'(phrases_q) * cols_q;
    avg_end = hit_end + 1 + cols_q;
    len_end = avg_end + cols_q;
    total   = len_end + cols_q;
    if (p < hit_end) begin
      k = p - 2;
      j = 32'((k / 3) % cols_q);
      if (k % 3 == 0) hit_sum_q[j] += w;
      else if (k % 3 == 2 && j >= 1) docs_q += w;
    end else if (p == hit_end) begin
      rows_q = w;
    end else if (p < avg_end) begin
      avg_q[p - hit_end - 1] = w;
    end else if (p < len_end) begin
      weigh_length(32'(p - avg_end), w);
    end else if (p >= total) begin
      err_q = ST_BAD;
    end
  endfunction

  function automatic rank_t final_score();
    rank_t res;
    logic [1:0] st;
    logic [31:0] sc;
    longint unsigned pn, h, an, mag, d, c, r, q;
    longint num, den;
    st = err_q; sc = 0;
    pn = longint'(phrases_q) * rows_q;
    h = docs_q;
    if (st == ST_OK && h == 0) st = ST_NO_HITS;
    if (st == ST_OK && pn < h) st = ST_LOG_ARG;
    if (st == ST_OK) begin
      num = log2_q16(2 * (pn - h) + 1) - log2_q16(2 * h);
      den = log2_q16(2 * pn + 1) - longint'(ONE_Q16);
      if (den <= 0) begin
        st = ST_LOG_ARG;
      end else begin
        an = (num < 0) ? -num : num;
        mag = (an << 30) / den;
        d = weight_q + 2 * ONE_Q16;
        c = ((64'd1 << 47) + d - 1) / d;
        r = (64'd1 << 30) - c;
        q = r * (mag >> 30) + ((r * (mag & 64'h3FFF_FFFF)) >> 30);
        if (num >= 0) sc = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        else sc = (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - q[31:0];
      end
    end
    res.score = (st == ST_OK) ? sc : '0;
    res.status = st;
    return res;
  endfunction

  function automatic void predict_word(word_t w, logic lst);
    longint unsigned total;
    if (err_q == ST_OK) absorb_word(w);
    if (lst) begin
      if (err_q == ST_OK) begin
        total = 3 + 3 * longint'(phrases_q) * cols_q + 3 * cols_q;
        if (pos_q < 2 || pos_q != total - 1) err_q = ST_BAD;
      end
      score_fifo.insert(score_fifo.size(), final_score());
      clear_predictor();
    end else if (pos_q != 32'hFFFF_FFFF) begin
      pos_q++;
    end
  endfunction

  task automatic send_word(word_t w, logic lst);
    @(negedge clk);
    if (!steady && $urandom_range(0, 5) == 0) begin
      blob_if.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    blob_if.valid = 1'b1;
    blob_if.word  = w;
    blob_if.last  = lst;
    do @(posedge clk); while (!blob_if.ready);
    predict_word(w, lst);
    words_sent++;
  endtask

  // sends n words of blob_q, random filler past its end, last on the final one
  task automatic play_blob(int n);
    for (int i = 0; i < n; i++)
      send_word((i < blob_q.size()) ? blob_q[i] : word_t'($urandom), i == n - 1);
    blobs_sent++;
  endtask

  function automatic word_t pick(int unsigned lim, int odds);
    if ($urandom_range(0, odds - 1) == 0) return $urandom;
    return $urandom_range(0, lim);
  endfunction

  function automatic void build_blob(int unsigned p, int unsigned c, val_style_e vs);
    bit top;
    top = (vs == VAL_MAX);
    blob_q = {};
    add_word(p);
    add_word(c);
    for (int i = 0; i < p * c; i++) begin
      add_word(top ? '1 : pick(12, 8));
      add_word($urandom);
      if (vs == VAL_NO_ROWS) add_word($urandom_range(1, 3));
      else add_word(top ? '1 : pick(3, 30));
    end
    if (vs == VAL_NO_ROWS) add_word('0);
    else add_word(top ? '1 : pick(40, 3));
    for (int i = 0; i < c; i++)
      add_word(top ? '1 : (vs == VAL_ZERO_AVG) ? '0 : pick(30, 5));
    for (int i = 0; i < c; i++)
      add_word(top ? '0 : pick(60, 5));
    for (int i = 0; i < c; i++)
      add_word($urandom);
  endfunction

  task automatic random_blob();
    int unsigned p, c, n, kind;
    val_style_e vs;
    p = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 3);
    c = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 4);
    kind = $urandom_range(0, 99);
    vs = (kind < 5) ? VAL_ZERO_AVG : (kind < 9) ? VAL_NO_ROWS :
         (kind < 12) ? VAL_MAX : VAL_MIXED;
    build_blob(p, c, vs);
    n = blob_q.size();
    kind = $urandom_range(0, 99);
    if (kind < 7) begin
      play_blob($urandom_range(1, n - 1));
    end else if (kind < 14) begin
      play_blob(n + $urandom_range(1, 3));
    end else if (kind < 20) begin
      if ($urandom_range(0, 1)) blob_q[0] = $urandom_range(NPHRASES + 1, 32'hFFFF_FFFF);
      else blob_q[1] = $urandom_range(NCOLS + 1, 32'hFFFF_FFFF);
      play_blob(n);
    end else begin
      play_blob(n);
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      rank_if.ready = 1'b0;
      stall_left--;
    end else if (!steady && $urandom_range(0, 7) == 0) begin
      rank_if.ready = 1'b0;
      stall_left = $urandom_range(1, 15) - 1;
    end else begin
      rank_if.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    rank_t exp_r;
    if (!rst && rank_if.valid && rank_if.ready) begin
      scores_seen++;
      if (score_fifo.size() == 0) begin
        $error("score returned with none pending: score=%0h status=%0d",
               rank_if.score, rank_if.status);
        mismatches++;
      end else begin
        exp_r = score_fifo.pop_front();
        status_hist[exp_r.status]++;
        if (rank_if.score !== exp_r.score) begin
          $error("score: expected %0h, got %0h", exp_r.score, rank_if.score);
          mismatches++;
        end
        if (rank_if.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, rank_if.status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((blob_if.valid && blob_if.ready) || (rank_if.valid && rank_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog: no request or result moved for %0d cycles", WDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_corner_blobs();
    blob_q = {0, 0, 5};
    play_blob(3);
    blob_q = {7};
    play_blob(1);
    blob_q = {1, 1};
    play_blob(2);
    blob_q = {NPHRASES, NCOLS, 9};
    play_blob(3);
    blob_q = {NPHRASES + 1, 1};
    play_blob(2);
    blob_q = {1, NCOLS + 1, 0};
    play_blob(3);
    build_blob(1, 2, VAL_MAX);
    play_blob(blob_q.size());
    build_blob(1, 2, VAL_ZERO_AVG);
    play_blob(blob_q.size());
    build_blob(1, 2, VAL_NO_ROWS);
    play_blob(blob_q.size());
    build_blob(1, 2, VAL_MIXED);
    play_blob(blob_q.size() + 1);
  endtask

  task automatic test_random_blobs();
    while (words_sent < 420) random_blob();
  endtask

  task automatic test_full_rate();
    steady = 1'b1;
    repeat (6) random_blob();
  endtask

  initial begin
    rst = 1'b1;
    blob_if.valid = 1'b0;
    blob_if.word  = '0;
    blob_if.last  = 1'b0;
    rank_if.ready = 1'b0;
    steady = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    clear_predictor();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_corner_blobs();
    test_random_blobs();
    test_full_rate();

    @(negedge clk);
    blob_if.valid = 1'b0;
    while (score_fifo.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("%0d blobs in %0d words, %0d scores checked", blobs_sent, words_sent,
             scores_seen);
    $display("status ok %0d, bad blob %0d, no hits %0d, log argument %0d",
             status_hist[0], status_hist[1], status_hist[2], status_hist[3]);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
